// File: rtl/cnt_pkg.sv
// Shared types, constants and helpers for the compound name tokenizer.
package cnt_pkg;

	localparam int MAX_META_DEF = 4;
	localparam int META_BYTES   = 4;
	localparam int META_W       = 35;
	localparam int IDX_W        = 3;
	localparam int QDEPTH       = 4;

	typedef enum logic [IDX_W-1:0] {
		REG_SEP  = 3'd0,
		REG_ESC  = 3'd1,
		REG_OQA  = 3'd2,
		REG_CQA  = 3'd3,
		REG_OQB  = 3'd4,
		REG_CQB  = 3'd5,
		REG_FLAT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]  len;
		logic [31:0] bytes;
	} meta_t;

	typedef struct packed {
		meta_t sep;
		meta_t esc;
		meta_t oqa;
		meta_t cqa;
		meta_t oqb;
		meta_t cqb;
		logic  flat;
	} cfg_t;

	typedef enum logic [2:0] {
		MODE_START,
		MODE_PLAIN,
		MODE_QUOTED,
		MODE_CLOSED,
		MODE_ERROR
	} mode_t;

	typedef struct packed {
		logic       fin;
		logic [7:0] data;
		logic       m_sep;
		logic       m_esc;
		logic       m_oqa;
		logic       m_oqb;
		logic       m_cqa;
		logic       m_cqb;
	} op_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       comp_done;
		logic       name_done;
		logic       name_error;
	} res_t;

	// Lengths of five to seven count as four.
	function automatic logic [2:0] eff_len(meta_t m);
		return (m.len > 3'd4) ? 3'd4 : m.len;
	endfunction

endpackage

// File: rtl/cnt_ifs.sv
// Channel interfaces: name bytes in, component results out, register writes.
interface cnt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       byte_present;
	logic       name_last;
	modport source (output valid, in_byte, byte_present, name_last, input ready);
	modport sink (input valid, in_byte, byte_present, name_last, output ready);
endinterface

interface cnt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       comp_done;
	logic       name_done;
	logic       name_error;
	modport source (output valid, out_byte, out_valid, comp_done, name_done, name_error,
		input ready);
	modport sink (input valid, out_byte, out_valid, comp_done, name_done, name_error,
		output ready);
endinterface

interface cnt_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [34:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/compound_name_tokenizer.sv
// Top level: registers, front end, operation queue and back end of the tokenizer.
// A completed result goes from the window through the operation queue into the output register.
// Throughput: one byte per cycle while the queue has room; a final byte holds the input
// while the window drains, one window operation per cycle unless the queue is full.
// Reset: all parse state, the window count, the queue and the output clear; registers
// take their reset values (separator '/', all other meta strings absent, flat mode off).
module compound_name_tokenizer import cnt_pkg::*; #(
	parameter int MAX_META = MAX_META_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cnt_in_if.sink    in_ch,
	cnt_out_if.source out_ch,
	cnt_cfg_if.sink   cfg_ch
);

	cfg_t cfg_q;
	logic q_full, q_push, q_valid, q_pop, drain;
	op_t  push_op, head_op;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{sep: '{len: 3'd1, bytes: 32'h0000_002F}, esc: '0, oqa: '0,
				cqa: '0, oqb: '0, cqb: '0, flat: 1'b0};
		end else if (cfg_ch.valid) begin
			case (reg_idx_t'(cfg_ch.index))
				REG_SEP:  cfg_q.sep  <= meta_t'(cfg_ch.data);
				REG_ESC:  cfg_q.esc  <= meta_t'(cfg_ch.data);
				REG_OQA:  cfg_q.oqa  <= meta_t'(cfg_ch.data);
				REG_CQA:  cfg_q.cqa  <= meta_t'(cfg_ch.data);
				REG_OQB:  cfg_q.oqb  <= meta_t'(cfg_ch.data);
				REG_CQB:  cfg_q.cqb  <= meta_t'(cfg_ch.data);
				REG_FLAT: cfg_q.flat <= cfg_ch.data[0];
				default: begin
				end
			endcase
		end
	end

	cnt_front #(.MAX_META(MAX_META)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.in     (in_ch),
		.q_full (q_full),
		.q_push (q_push),
		.q_op   (push_op),
		.drain  (drain)
	);

	cnt_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.op_in  (push_op),
		.full   (q_full),
		.valid  (q_valid),
		.op_out (head_op),
		.pop    (q_pop)
	);

	cnt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_op    (head_op),
		.q_pop   (q_pop),
		.out     (out_ch)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("operation pushed into a full queue");

	a_drain_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		drain |-> !in_ch.ready)
		else $error("input taken while the window drains");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.name_error) |->
			(out_ch.name_done && !out_ch.comp_done && !out_ch.out_valid))
		else $error("error result is not a bare end of name");

endmodule

// File: rtl/cnt_front.sv
// Front end: lookahead window, meta string matching and drain at the end of a name.
module cnt_front import cnt_pkg::*; #(
	parameter int MAX_META = MAX_META_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	cnt_in_if.sink in,
	input  logic   q_full,
	output logic   q_push,
	output op_t    q_op,
	output logic   drain
);

	localparam int CW   = $clog2(MAX_META + 1);
	localparam int NCMP = (MAX_META < META_BYTES) ? MAX_META : META_BYTES;

	logic [7:0]            win_q [MAX_META];
	logic [7:0]            win_in [MAX_META];
	logic [7:0]            cur_win [MAX_META];
	logic [7:0]            shifted [MAX_META];
	logic [8*MAX_META-1:0] cur_flat;
	logic [CW-1:0]         cnt_q, cnt_in, cur_cnt, cnt_m1;
	logic                  drain_q, accept, do_pop, do_fin;

	function automatic logic meta_hit(meta_t m, logic [8*MAX_META-1:0] w, logic [CW-1:0] c);
		logic [2:0] l;
		logic       hit;
		l = eff_len(m);
		hit = (l != 3'd0) && (int'(l) <= int'(c));
		for (int i = 0; i < NCMP; i++) begin
			if (i < int'(l) && w[8*i +: 8] != m.bytes[8*i +: 8]) begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

	assign in.ready = !drain_q && !q_full;
	assign accept   = in.valid && in.ready;
	assign drain    = drain_q;

	always_comb begin
		for (int i = 0; i < MAX_META; i++) begin
			win_in[i] = (in.byte_present && cnt_q == CW'(i)) ? in.in_byte : win_q[i];
		end
		cnt_in  = cnt_q + CW'(in.byte_present);
		cur_win = drain_q ? win_q : win_in;
		cur_cnt = drain_q ? cnt_q : cnt_in;
		cnt_m1  = cur_cnt - CW'(1);
		for (int i = 0; i < MAX_META; i++) begin
			cur_flat[8*i +: 8] = cur_win[i];
		end
		for (int i = 0; i < MAX_META - 1; i++) begin
			shifted[i] = cur_win[i+1];
		end
		shifted[MAX_META-1] = 8'd0;
	end

	always_comb begin
		do_pop = 1'b0;
		do_fin = 1'b0;
		if (drain_q || (accept && in.name_last)) begin
			do_pop = (cur_cnt != '0);
			do_fin = (cur_cnt == '0);
		end else if (accept) begin
			do_pop = (cur_cnt == CW'(MAX_META));
		end
	end

	assign q_push = (do_pop || do_fin) && !q_full;

	always_comb begin
		q_op.fin   = do_fin;
		q_op.data  = cur_win[0];
		q_op.m_sep = !cfg.flat && meta_hit(cfg.sep, cur_flat, cur_cnt);
		q_op.m_esc = meta_hit(cfg.esc, cur_flat, cur_cnt);
		q_op.m_oqa = meta_hit(cfg.oqa, cur_flat, cur_cnt);
		q_op.m_oqb = meta_hit(cfg.oqb, cur_flat, cur_cnt);
		q_op.m_cqa = meta_hit(cfg.cqa, cur_flat, cur_cnt);
		q_op.m_cqb = meta_hit(cfg.cqb, cur_flat, cur_cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			drain_q <= 1'b0;
		end else if (drain_q) begin
			if (!q_full) begin
				if (do_pop) begin
					cnt_q <= cnt_m1;
				end else begin
					cnt_q   <= '0;
					drain_q <= 1'b0;
				end
			end
		end else if (accept) begin
			if (do_pop) begin
				cnt_q   <= cnt_m1;
				drain_q <= in.name_last;
			end else if (do_fin) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((drain_q && !q_full && do_pop) || (accept && do_pop)) begin
			win_q <= shifted;
		end else if (accept && !do_fin) begin
			win_q <= win_in;
		end
	end

endmodule

// File: rtl/cnt_queue.sv
// Short queue of classified window operations between front and back.
module cnt_queue import cnt_pkg::*; #(
	parameter int DEPTH = QDEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  op_in,
	output logic full,
	output logic valid,
	output op_t  op_out,
	input  logic pop
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [NW-1:0] fill_q;
	logic          do_push, do_pop;

	assign full    = (fill_q == NW'(DEPTH));
	assign valid   = (fill_q != '0);
	assign op_out  = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= op_in;
		end
	end

endmodule

// File: rtl/cnt_back.sv
// Back end: parse state machine over window operations and the output register.
module cnt_back import cnt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_valid,
	input  op_t        q_op,
	output logic       q_pop,
	cnt_out_if.source  out
);

	mode_t      mode_q, mode_d;
	logic       qk_q, qk_d, lit_q, lit_d;
	logic [2:0] skip_q, skip_d;
	logic [2:0] cq_len, cq_skip, sep_skip, esc_skip, oqa_skip, oqb_skip;
	logic       m_cq, take, has_res, ov_q;
	res_t       res_d, res_q, byte_res, comp_res;

	assign m_cq     = qk_q ? q_op.m_cqb : q_op.m_cqa;
	assign cq_len   = eff_len(qk_q ? cfg.cqb : cfg.cqa);
	assign cq_skip  = cq_len - 3'd1;
	assign sep_skip = eff_len(cfg.sep) - 3'd1;
	assign esc_skip = eff_len(cfg.esc) - 3'd1;
	assign oqa_skip = eff_len(cfg.oqa) - 3'd1;
	assign oqb_skip = eff_len(cfg.oqb) - 3'd1;

	assign take  = q_valid && (!ov_q || out.ready);
	assign q_pop = take;

	assign byte_res = '{out_byte: q_op.data, out_valid: 1'b1, default: 1'b0};
	assign comp_res = '{out_byte: 8'd0, comp_done: 1'b1, default: 1'b0};

	// Next state.
	always_comb begin
		mode_d = mode_q;
		qk_d   = qk_q;
		skip_d = skip_q;
		lit_d  = lit_q;
		if (q_op.fin) begin
			mode_d = MODE_START;
			qk_d   = 1'b0;
			skip_d = 3'd0;
			lit_d  = 1'b0;
		end else if (skip_q != 3'd0) begin
			skip_d = skip_q - 3'd1;
		end else begin
			case (mode_q)
				MODE_ERROR: begin
				end
				MODE_QUOTED: begin
					if (lit_q) begin
						lit_d = 1'b0;
					end else if (cq_len == 3'd0) begin
						// An empty close quote ends the quote at once; this byte
						// must then be a separator.
						if (q_op.m_sep) begin
							skip_d = sep_skip;
							mode_d = MODE_START;
						end else begin
							mode_d = MODE_ERROR;
						end
					end else if (m_cq) begin
						skip_d = cq_skip;
						mode_d = MODE_CLOSED;
					end else if (q_op.m_esc) begin
						skip_d = esc_skip;
						lit_d  = 1'b1;
					end
				end
				MODE_CLOSED: begin
					if (q_op.m_sep) begin
						skip_d = sep_skip;
						mode_d = MODE_START;
					end else begin
						mode_d = MODE_ERROR;
					end
				end
				default: begin
					if (lit_q) begin
						lit_d  = 1'b0;
						mode_d = MODE_PLAIN;
					end else if (mode_q == MODE_START && q_op.m_oqa) begin
						skip_d = oqa_skip;
						qk_d   = 1'b0;
						mode_d = MODE_QUOTED;
					end else if (mode_q == MODE_START && q_op.m_oqb) begin
						skip_d = oqb_skip;
						qk_d   = 1'b1;
						mode_d = MODE_QUOTED;
					end else if (q_op.m_esc) begin
						skip_d = esc_skip;
						lit_d  = 1'b1;
						mode_d = MODE_PLAIN;
					end else if (q_op.m_sep) begin
						skip_d = sep_skip;
						mode_d = MODE_START;
					end else begin
						mode_d = MODE_PLAIN;
					end
				end
			endcase
		end
	end

	// Result of the operation.
	always_comb begin
		has_res = 1'b0;
		res_d   = byte_res;
		if (q_op.fin) begin
			has_res = 1'b1;
			if (mode_q == MODE_ERROR || mode_q == MODE_QUOTED || lit_q) begin
				res_d = '{out_byte: 8'd0, name_done: 1'b1, name_error: 1'b1, default: 1'b0};
			end else begin
				res_d = '{out_byte: 8'd0, comp_done: 1'b1, name_done: 1'b1, default: 1'b0};
			end
		end else if (skip_q == 3'd0) begin
			case (mode_q)
				MODE_ERROR: begin
				end
				MODE_QUOTED: begin
					if (lit_q) begin
						has_res = 1'b1;
					end else if (cq_len == 3'd0) begin
						has_res = q_op.m_sep;
						res_d   = comp_res;
					end else if (!m_cq && !q_op.m_esc) begin
						has_res = 1'b1;
					end
				end
				MODE_CLOSED: begin
					has_res = q_op.m_sep;
					res_d   = comp_res;
				end
				default: begin
					if (lit_q) begin
						has_res = 1'b1;
					end else if (mode_q == MODE_START && (q_op.m_oqa || q_op.m_oqb)) begin
						has_res = 1'b0;
					end else if (q_op.m_esc) begin
						has_res = 1'b0;
					end else if (q_op.m_sep) begin
						has_res = 1'b1;
						res_d   = comp_res;
					end else begin
						has_res = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			qk_q   <= 1'b0;
			skip_q <= 3'd0;
			lit_q  <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (take) begin
				mode_q <= mode_d;
				qk_q   <= qk_d;
				skip_q <= skip_d;
				lit_q  <= lit_d;
			end
			if (take && has_res) begin
				ov_q <= 1'b1;
			end else if (out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && has_res) begin
			res_q <= res_d;
		end
	end

	assign out.valid      = ov_q;
	assign out.out_byte   = res_q.out_byte;
	assign out.out_valid  = res_q.out_valid;
	assign out.comp_done  = res_q.comp_done;
	assign out.name_done  = res_q.name_done;
	assign out.name_error = res_q.name_error;

endmodule

// File: tb/compound_name_tokenizer_tb.sv
// Testbench for the compound name tokenizer: random and directed names checked against a predictor.
module compound_name_tokenizer_tb;
	import cnt_pkg::*;

	localparam int                 WIN         = MAX_META_DEF;
	localparam int                 STALL_LIMIT = 5000;
	localparam logic [IDX_W-1:0]   REG_BEYOND  = 3'd7;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       ends;
	} name_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [META_W-1:0] val;
	} reg_write_t;

	logic clk;
	logic arst_n;

	cnt_in_if  in_ch();
	cnt_out_if out_ch();
	cnt_cfg_if cfg_ch();

	compound_name_tokenizer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	name_item_t  byte_items[$];
	reg_write_t  reg_writes[$];
	res_t        expected_tokens[$];
	int          send_gap_pct;
	int          recv_stall_pct;
	int          fault_count;
	int          quiet_cycles;

	cfg_t        regs;
	logic [7:0]  win [WIN];
	int unsigned win_cnt;
	mode_t       pmode;
	logic        qkind;
	logic        lit_pend;
	int unsigned skip_left;

	always #4 clk = ~clk;

	task automatic report(string what);
		if (fault_count < 100) begin
			$display("mismatch: %s", what);
		end
		fault_count++;
	endtask

	function automatic int meta_size(meta_t m);
		if (m.len > 3'd4) begin
			return 4;
		end
		return int'(m.len);
	endfunction

	function automatic bit window_has(meta_t m);
		int n;
		int i;
		n = meta_size(m);
		if (n == 0 || n > win_cnt) begin
			return 1'b0;
		end
		for (i = 0; i < n; i++) begin
			if (win[i] != m.bytes[8*i +: 8]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic bit sep_hit();
		return !regs.flat && window_has(regs.sep);
	endfunction

	task automatic emit(logic [7:0] b, logic v, logic c, logic d, logic e);
		expected_tokens.push_back(res_t'{b, v, c, d, e});
	endtask

	task automatic clear_parse();
		int i;
		for (i = 0; i < WIN; i++) begin
			win[i] = 8'h00;
		end
		win_cnt = 0;
		pmode = MODE_START;
		qkind = 1'b0;
		skip_left = 0;
		lit_pend = 1'b0;
	endtask

	task automatic apply_reg(logic [IDX_W-1:0] idx, logic [META_W-1:0] val);
		case (idx)
			REG_SEP: regs.sep = val;
			REG_ESC: regs.esc = val;
			REG_OQA: regs.oqa = val;
			REG_CQA: regs.cqa = val;
			REG_OQB: regs.oqb = val;
			REG_CQB: regs.cqb = val;
			REG_FLAT: regs.flat = val[0];
			default: ;
		endcase
	endtask

	task automatic handle_front();
		logic [7:0] b;
		meta_t      cq;
		b = win[0];
		cq = qkind ? regs.cqb : regs.cqa;
		if (skip_left != 0) begin
			skip_left--;
			return;
		end
		if (pmode == MODE_ERROR) begin
			return;
		end
		if (pmode == MODE_QUOTED) begin
			if (lit_pend) begin
				lit_pend = 1'b0;
				emit(b, 1'b1, 1'b0, 1'b0, 1'b0);
				return;
			end
			if (meta_size(cq) == 0) begin
				pmode = MODE_CLOSED;
			end else if (window_has(cq)) begin
				skip_left = meta_size(cq) - 1;
				pmode = MODE_CLOSED;
				return;
			end else if (window_has(regs.esc)) begin
				skip_left = meta_size(regs.esc) - 1;
				lit_pend = 1'b1;
				return;
			end else begin
				emit(b, 1'b1, 1'b0, 1'b0, 1'b0);
				return;
			end
		end
		if (pmode == MODE_CLOSED) begin
			if (sep_hit()) begin
				skip_left = meta_size(regs.sep) - 1;
				emit(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
				pmode = MODE_START;
			end else begin
				pmode = MODE_ERROR;
			end
			return;
		end
		if (lit_pend) begin
			lit_pend = 1'b0;
			pmode = MODE_PLAIN;
			emit(b, 1'b1, 1'b0, 1'b0, 1'b0);
			return;
		end
		if (pmode == MODE_START) begin
			if (window_has(regs.oqa)) begin
				skip_left = meta_size(regs.oqa) - 1;
				qkind = 1'b0;
				pmode = MODE_QUOTED;
				return;
			end
			if (window_has(regs.oqb)) begin
				skip_left = meta_size(regs.oqb) - 1;
				qkind = 1'b1;
				pmode = MODE_QUOTED;
				return;
			end
		end
		if (window_has(regs.esc)) begin
			skip_left = meta_size(regs.esc) - 1;
			lit_pend = 1'b1;
			pmode = MODE_PLAIN;
			return;
		end
		if (sep_hit()) begin
			skip_left = meta_size(regs.sep) - 1;
			emit(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
			pmode = MODE_START;
			return;
		end
		emit(b, 1'b1, 1'b0, 1'b0, 1'b0);
		pmode = MODE_PLAIN;
	endtask

	task automatic pop_front();
		int i;
		if (win_cnt == 0) begin
			return;
		end
		handle_front();
		for (i = 1; i < win_cnt; i++) begin
			win[i-1] = win[i];
		end
		win_cnt--;
		win[win_cnt] = 8'h00;
	endtask

	task automatic tokenize_byte(logic [7:0] b, logic present, logic ends);
		if (present && win_cnt < WIN) begin
			win[win_cnt] = b;
			win_cnt++;
		end
		if (ends) begin
			while (win_cnt > 0) begin
				pop_front();
			end
			if (pmode == MODE_ERROR || pmode == MODE_QUOTED || lit_pend) begin
				emit(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
			end else begin
				emit(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
			end
			clear_parse();
		end else if (win_cnt >= WIN) begin
			pop_front();
		end
	endtask

	always @(posedge clk) begin : drive_names
		name_item_t nxt;
		if (in_ch.valid && in_ch.ready) begin
			tokenize_byte(in_ch.in_byte, in_ch.byte_present, in_ch.name_last);
		end
		if (!in_ch.valid || in_ch.ready) begin
			if (arst_n && byte_items.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
				nxt = byte_items.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.in_byte <= nxt.data;
				in_ch.byte_present <= nxt.present;
				in_ch.name_last <= nxt.ends;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : drive_regs
		reg_write_t w;
		if (cfg_ch.valid && cfg_ch.ready) begin
			apply_reg(cfg_ch.index, cfg_ch.data);
		end
		if (!cfg_ch.valid || cfg_ch.ready) begin
			if (arst_n && reg_writes.size() != 0) begin
				w = reg_writes.pop_front();
				cfg_ch.valid <= 1'b1;
				cfg_ch.index <= w.idx;
				cfg_ch.data <= w.val;
			end else begin
				cfg_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_tokens
		res_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_tokens.size() == 0) begin
				report($sformatf("result with nothing expected, byte %h", out_ch.out_byte));
			end else begin
				want = expected_tokens.pop_front();
				if (out_ch.out_byte !== want.out_byte) begin
					report($sformatf("out_byte %h, want %h", out_ch.out_byte, want.out_byte));
				end
				if (out_ch.out_valid !== want.out_valid) begin
					report($sformatf("out_valid %b, want %b", out_ch.out_valid, want.out_valid));
				end
				if (out_ch.comp_done !== want.comp_done) begin
					report($sformatf("comp_done %b, want %b", out_ch.comp_done, want.comp_done));
				end
				if (out_ch.name_done !== want.name_done) begin
					report($sformatf("name_done %b, want %b", out_ch.name_done, want.name_done));
				end
				if (out_ch.name_error !== want.name_error) begin
					report($sformatf("name_error %b, want %b", out_ch.name_error,
						want.name_error));
				end
			end
		end
		out_ch.ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("compound_name_tokenizer_tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic settle(int extra_cycles);
		do begin
			@(posedge clk);
		end while (byte_items.size() != 0 || in_ch.valid || reg_writes.size() != 0
			|| cfg_ch.valid || expected_tokens.size() != 0);
		repeat (extra_cycles) @(posedge clk);
	endtask

	task automatic set_reg(logic [IDX_W-1:0] idx, logic [META_W-1:0] val);
		reg_writes.push_back(reg_write_t'{idx, val});
	endtask

	function automatic logic [META_W-1:0] meta_of(string s);
		logic [META_W-1:0] v;
		int i;
		v = '0;
		v[34:32] = 3'(s.len());
		for (i = 0; i < s.len(); i++) begin
			v[8*i +: 8] = s[i];
		end
		return v;
	endfunction

	function automatic logic [META_W-1:0] random_meta();
		logic [META_W-1:0] v;
		int i;
		string pool;
		pool = "ab:/\"";
		v[34:32] = 3'($urandom_range(0, 7));
		for (i = 0; i < 4; i++) begin
			v[8*i +: 8] = pool[$urandom_range(0, 4)];
		end
		return v;
	endfunction

	task automatic push_name(string s);
		int i;
		if (s.len() == 0) begin
			byte_items.push_back(name_item_t'{8'h00, 1'b0, 1'b1});
		end
		for (i = 0; i < s.len(); i++) begin
			byte_items.push_back(name_item_t'{s[i], 1'b1, i == s.len() - 1});
		end
	endtask

	task automatic add_meta(meta_t m, ref logic [7:0] txt[$]);
		int n;
		int i;
		n = meta_size(m);
		if (n > 1 && $urandom_range(0, 7) == 0) begin
			n = 1;
		end
		for (i = 0; i < n; i++) begin
			txt.push_back(m.bytes[8*i +: 8]);
		end
	endtask

	task automatic random_name(output int made);
		logic [7:0] txt[$];
		logic [7:0] junk;
		meta_t      close_q;
		int         ncomp;
		int         c;
		int         t;
		int         k;
		int         i;
		bit         quoted;
		bit         tail_empty;
		close_q = '0;
		ncomp = $urandom_range(1, 3);
		for (c = 0; c < ncomp; c++) begin
			if (c != 0) begin
				add_meta(regs.sep, txt);
			end
			k = $urandom_range(0, 9);
			quoted = k < 5;
			if (k < 3) begin
				add_meta(regs.oqa, txt);
				close_q = regs.cqa;
			end else if (k < 5) begin
				add_meta(regs.oqb, txt);
				close_q = regs.cqb;
			end
			for (t = $urandom_range(0, 4); t > 0; t--) begin
				k = $urandom_range(0, 9);
				junk = 8'($urandom_range(0, 255));
				if (k < 5) begin
					txt.push_back(8'(8'h61 + $urandom_range(0, 2)));
				end else if (k < 7) begin
					txt.push_back(junk);
				end else if (k < 9) begin
					add_meta(regs.esc, txt);
					txt.push_back($urandom_range(0, 1) ? junk : regs.sep.bytes[7:0]);
				end else begin
					add_meta(regs.sep, txt);
				end
			end
			if (quoted && $urandom_range(0, 9) != 0) begin
				add_meta(close_q, txt);
			end
		end
		if ($urandom_range(0, 7) == 0) begin
			add_meta(regs.sep, txt);
		end
		if (txt.size() != 0 && $urandom_range(0, 4) == 0) begin
			k = $urandom_range(0, txt.size() - 1);
			if ($urandom_range(0, 1)) begin
				txt[k] = 8'($urandom_range(0, 255));
			end else begin
				while (txt.size() > k) begin
					void'(txt.pop_back());
				end
			end
		end
		if (txt.size() == 0) begin
			byte_items.push_back(name_item_t'{8'h00, 1'b0, 1'b1});
			made = 1;
			return;
		end
		tail_empty = $urandom_range(0, 5) == 0;
		for (i = 0; i < txt.size(); i++) begin
			if ($urandom_range(0, 11) == 0) begin
				junk = 8'($urandom_range(0, 255));
				byte_items.push_back(name_item_t'{junk, 1'b0, 1'b0});
			end
			byte_items.push_back(name_item_t'{txt[i], 1'b1, !tail_empty && i == txt.size() - 1});
		end
		if (tail_empty) begin
			junk = 8'($urandom_range(0, 255));
			byte_items.push_back(name_item_t'{junk, 1'b0, 1'b1});
		end
		made = txt.size() + int'(tail_empty);
	endtask

	// Halfway through, no new names are queued until the block has returned every result.
	task automatic random_names(int target);
		int  made;
		int  got;
		bit  paused;
		got = 0;
		paused = 1'b0;
		while (got < target) begin
			random_name(made);
			got += made;
			if (!paused && got >= target / 2) begin
				paused = 1'b1;
				settle(0);
			end
		end
		settle(8);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.byte_present = 1'b0;
		in_ch.name_last = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		fault_count = 0;
		quiet_cycles = 0;
		regs = '0;
		regs.sep = meta_of("/");
		clear_parse();
		send_gap_pct = 30;
		recv_stall_pct = 88;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		push_name("a/b");
		push_name("");
		push_name("c/");
		byte_items.push_back(name_item_t'{8'h00, 1'b1, 1'b0});
		byte_items.push_back(name_item_t'{8'hA5, 1'b0, 1'b0});
		byte_items.push_back(name_item_t'{8'hFF, 1'b1, 1'b0});
		byte_items.push_back(name_item_t'{8'h5A, 1'b0, 1'b1});
		settle(8);

		set_reg(REG_SEP, meta_of("::"));
		set_reg(REG_ESC, meta_of("\\"));
		set_reg(REG_OQA, meta_of("\""));
		set_reg(REG_CQA, meta_of("\""));
		set_reg(REG_OQB, meta_of("<<"));
		set_reg(REG_CQB, meta_of(">>"));
		set_reg(REG_FLAT, '0);
		settle(8);
		push_name("\"::\"");
		push_name("a\\");
		push_name("\"a\\");
		push_name("\"a\"b");
		push_name("b:");
		random_names(15);

		send_gap_pct = 88;
		recv_stall_pct = 30;
		set_reg(REG_SEP, 35'h7_FFFF_FFFF);
		set_reg(REG_ESC, {3'd5, 32'h6565_6565});
		set_reg(REG_OQA, meta_of("'"));
		set_reg(REG_CQA, '0);
		set_reg(REG_OQB, {3'd6, 32'h3C3C_3C3C});
		set_reg(REG_CQB, meta_of(">>>>"));
		settle(8);
		push_name(string'({8'hFF, 8'hFF, 8'hFF, 8'hFF, "a"}));
		push_name("'a");
		push_name("'");
		random_names(12);

		set_reg(REG_FLAT, 35'h1);
		settle(8);
		random_names(10);

		set_reg(REG_SEP, '0);
		set_reg(REG_ESC, '0);
		set_reg(REG_OQA, '0);
		set_reg(REG_CQA, '0);
		set_reg(REG_OQB, '0);
		set_reg(REG_CQB, '0);
		set_reg(REG_FLAT, '0);
		set_reg(REG_BEYOND, META_W'({$urandom, $urandom}));
		settle(8);
		random_names(8);

		send_gap_pct = 0;
		recv_stall_pct = 0;
		repeat (2) begin
			set_reg(REG_SEP, random_meta());
			set_reg(REG_ESC, random_meta());
			set_reg(REG_OQA, random_meta());
			set_reg(REG_CQA, random_meta());
			set_reg(REG_OQB, random_meta());
			set_reg(REG_CQB, random_meta());
			set_reg(REG_FLAT, ($urandom_range(0, 3) == 0) ? 35'h1 : 35'h0);
			settle(8);
			random_names(10);
		end

		settle(10);
		if (fault_count == 0) begin
			$display("compound_name_tokenizer_tb: clean");
		end else begin
			$display("compound_name_tokenizer_tb: errors");
		end
		$finish;
	end

endmodule
